@@ rtl/stc_pkg.sv @@
// ----------------------------------------------------------------------------
// stc_pkg
// Shared request, response, cell link and control types for the sorted table.
// ----------------------------------------------------------------------------
package stc_pkg;

  localparam int KEY_W     = 32;
  localparam int PAYLOAD_W = 16;
  localparam int SLOT_W    = 6;
  localparam int COUNT_W   = 7;
  localparam int OUTCOME_W = 2;

  localparam logic [OUTCOME_W-1:0] OUTCOME_INSERTED = 2'd0;
  localparam logic [OUTCOME_W-1:0] OUTCOME_REPLACED = 2'd1;
  localparam logic [OUTCOME_W-1:0] OUTCOME_DROPPED  = 2'd2;

  typedef struct packed {
    logic [KEY_W-1:0]     position_key;
    logic [PAYLOAD_W-1:0] payload_handle;
  } req_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [SLOT_W-1:0]    slot;
    logic [COUNT_W-1:0]   entry_count;
  } rsp_t;

  // Data one cell hands to its upper neighbor.
  typedef struct packed {
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
    logic                 lt;
  } link_t;

  // Broadcast control from the top level to every cell.
  typedef struct packed {
    logic                 cmp;
    logic                 upd;
    logic                 rep;
    logic                 ins;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } ctrl_t;

endpackage

@@ rtl/stc_cell.sv @@
// ----------------------------------------------------------------------------
// stc_cell
// One slot of the sorted table: holds a key and payload, compares against the
// broadcast key, shifts up from below on insert and swaps payload on a match.
// ----------------------------------------------------------------------------
module stc_cell #(
  parameter int INDEX = 0,
  parameter int CNT_W = 7
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  stc_pkg::ctrl_t       ctrl,
  input  logic [CNT_W-1:0]     count,
  input  stc_pkg::link_t       prev,
  output stc_pkg::link_t       link,
  output logic                 pos_hit,
  output logic                 eq_hit
);

  logic [stc_pkg::KEY_W-1:0]     key_r;
  logic [stc_pkg::PAYLOAD_W-1:0] payload_r;
  logic                          lt_r;
  logic                          eq_r;
  logic                          valid;

  assign valid = CNT_W'(INDEX) < count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctrl.cmp) begin
      lt_r <= valid && (key_r < ctrl.key);
      eq_r <= valid && (key_r == ctrl.key);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.upd) begin
      if (ctrl.rep) begin
        if (eq_r) begin
          payload_r <= ctrl.payload;
        end
      end else if (ctrl.ins && !lt_r) begin
        if (prev.lt) begin
          key_r     <= ctrl.key;
          payload_r <= ctrl.payload;
        end else begin
          key_r     <= prev.key;
          payload_r <= prev.payload;
        end
      end
    end
  end

  assign link.key     = key_r;
  assign link.payload = payload_r;
  assign link.lt      = lt_r;
  assign pos_hit      = !lt_r && prev.lt;
  assign eq_hit       = eq_r;

endmodule

@@ rtl/sorted_table_insert_replace.sv @@
// ----------------------------------------------------------------------------
// sorted_table_insert_replace
// Sorted key table with insert-or-replace, built as a row of compare cells.
// ----------------------------------------------------------------------------
// For each request, in the cycle of acceptance every cell compares its key
// with the request key, and in the next cycle the cells replace, shift or
// hold and the response is registered. busy is high for that one update
// cycle, so a new request can follow only once busy is low again, independent
// of TABLE_DEPTH. The response appears on out_rsp with out_valid for exactly
// one cycle, the cycle after the update, and must be taken then.
module sorted_table_insert_replace #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  stc_pkg::req_t in_req,
  output logic          out_valid,
  output stc_pkg::rsp_t out_rsp
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic                          busy_r;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic [stc_pkg::KEY_W-1:0]     key_r;
  logic [stc_pkg::PAYLOAD_W-1:0] payload_r;
  logic                          out_valid_r;
  stc_pkg::rsp_t                 rsp_r;
  stc_pkg::rsp_t                 rsp_nxt;

  stc_pkg::ctrl_t                ctrl;
  stc_pkg::link_t                head;
  stc_pkg::link_t                links [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0]        pos_hits;
  logic [TABLE_DEPTH-1:0]        eq_hits;
  logic [IDX_W-1:0]              pos_idx;
  logic                          accept;
  logic                          full;

  assign accept = start && !busy_r;
  assign full   = count_r == CNT_W'(TABLE_DEPTH);

  assign ctrl.cmp     = accept;
  assign ctrl.upd     = busy_r;
  assign ctrl.rep     = |eq_hits;
  assign ctrl.ins     = !(|eq_hits) && !full;
  assign ctrl.key     = busy_r ? key_r : in_req.position_key;
  assign ctrl.payload = payload_r;

  assign head.key     = '0;
  assign head.payload = '0;
  assign head.lt      = 1'b1;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    stc_cell #(
      .INDEX(i),
      .CNT_W(CNT_W)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .count  (count_r),
      .prev   ((i == 0) ? head : links[(i == 0) ? 0 : i - 1]),
      .link   (links[i]),
      .pos_hit(pos_hits[i]),
      .eq_hit (eq_hits[i])
    );
  end

  always_comb begin
    pos_idx = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (pos_hits[i]) begin
        pos_idx = pos_idx | IDX_W'(i);
      end
    end
  end

  always_comb begin
    count_nxt = count_r + CNT_W'(ctrl.ins);
    rsp_nxt.entry_count = stc_pkg::COUNT_W'(count_nxt);
    if (ctrl.rep) begin
      rsp_nxt.outcome = stc_pkg::OUTCOME_REPLACED;
      rsp_nxt.slot    = stc_pkg::SLOT_W'(pos_idx);
    end else if (full) begin
      rsp_nxt.outcome = stc_pkg::OUTCOME_DROPPED;
      rsp_nxt.slot    = '0;
    end else begin
      rsp_nxt.outcome = stc_pkg::OUTCOME_INSERTED;
      rsp_nxt.slot    = stc_pkg::SLOT_W'(pos_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= accept;
      out_valid_r <= busy_r;
      if (busy_r) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_r     <= in_req.position_key;
      payload_r <= in_req.payload_handle;
    end
    if (busy_r) begin
      rsp_r <= rsp_nxt;
    end
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

endmodule

@@ rtl/stc_checker.sv @@
// ----------------------------------------------------------------------------
// stc_checker
// Port-level timing and response checks for the sorted table.
// ----------------------------------------------------------------------------
module stc_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_valid,
  input stc_pkg::rsp_t out_rsp
);

  a_resp_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_valid)
    else $error("Response did not follow request by two cycles.");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("Response strobe lasted more than one cycle.");

  a_drop_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.outcome == stc_pkg::OUTCOME_DROPPED) |->
      (out_rsp.slot == '0 &&
       out_rsp.entry_count == stc_pkg::COUNT_W'(TABLE_DEPTH)))
    else $error("Dropped request reported wrong slot or count.");

  a_outcome_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_rsp.outcome == stc_pkg::OUTCOME_INSERTED ||
                   out_rsp.outcome == stc_pkg::OUTCOME_REPLACED ||
                   out_rsp.outcome == stc_pkg::OUTCOME_DROPPED))
    else $error("Response carried an unknown outcome code.");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_rsp.outcome == stc_pkg::OUTCOME_INSERTED) |->
      out_rsp.entry_count != '0)
    else $error("Insert reported an empty table.");

endmodule

bind sorted_table_insert_replace stc_checker #(
  .TABLE_DEPTH(TABLE_DEPTH)
) u_stc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .start    (start),
  .busy     (busy),
  .out_valid(out_valid),
  .out_rsp  (out_rsp)
);

@@ tb/sorted_table_insert_replace_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_table_insert_replace_tb
// Self-checking testbench for the sorted key table with insert-or-replace.
// A local copy of the table predicts the outcome, slot and entry count of
// every accepted request. Directed requests cover the empty table, the key
// extremes, front, middle and end insertion and replacement. Random requests
// then fill the table, and a long random run hits it while full with a mix
// of replacements and dropped new keys. The request side varies through
// random gaps and gap-free bursts.
// ----------------------------------------------------------------------------
module sorted_table_insert_replace_tb;

  localparam int TABLE_DEPTH = 64;
  localparam int IDLE_LIMIT  = 2000;
  localparam int FULL_ITEMS  = 700;

  logic           clk;
  logic           rst_n;
  logic           start;
  logic           busy;
  stc_pkg::req_t  in_req;
  logic           out_valid;
  stc_pkg::rsp_t  out_rsp;

  logic [stc_pkg::KEY_W-1:0]     tbl_key [TABLE_DEPTH];
  logic [stc_pkg::PAYLOAD_W-1:0] tbl_payload [TABLE_DEPTH];
  int                            tbl_count;
  stc_pkg::rsp_t                 pending_rsp [$];
  int                            mismatches;
  int                            idle_cycles;
  int                            burst_left;

  sorted_table_insert_replace #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_req   (in_req),
    .out_valid(out_valid),
    .out_rsp  (out_rsp)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic stc_pkg::rsp_t table_update(stc_pkg::req_t r);
    int            pos;
    int            j;
    stc_pkg::rsp_t res;
    pos = 0;
    while (pos < tbl_count && tbl_key[pos] < r.position_key) pos++;
    if (pos < tbl_count && tbl_key[pos] == r.position_key) begin
      tbl_payload[pos] = r.payload_handle;
      res.outcome = stc_pkg::OUTCOME_REPLACED;
      res.slot    = pos[stc_pkg::SLOT_W-1:0];
    end else if (tbl_count >= TABLE_DEPTH) begin
      res.outcome = stc_pkg::OUTCOME_DROPPED;
      res.slot    = '0;
    end else begin
      for (j = tbl_count; j > pos; j--) begin
        tbl_key[j]     = tbl_key[j-1];
        tbl_payload[j] = tbl_payload[j-1];
      end
      tbl_key[pos]     = r.position_key;
      tbl_payload[pos] = r.payload_handle;
      tbl_count++;
      res.outcome = stc_pkg::OUTCOME_INSERTED;
      res.slot    = pos[stc_pkg::SLOT_W-1:0];
    end
    res.entry_count = tbl_count[stc_pkg::COUNT_W-1:0];
    return res;
  endfunction

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if (roll < 4) begin
      burst_left = $urandom_range(10, 30);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(logic [stc_pkg::KEY_W-1:0]     key,
                               logic [stc_pkg::PAYLOAD_W-1:0] handle);
    stc_pkg::req_t r;
    stc_pkg::rsp_t predicted;
    r.position_key   = key;
    r.payload_handle = handle;
    @(negedge clk);
    start  <= 1'b1;
    in_req <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted   = table_update(r);
    pending_rsp = {pending_rsp, predicted};
  endtask

  task automatic hold_off(int cycles);
    if (cycles > 0) begin
      @(negedge clk);
      start  <= 1'b0;
      in_req <= {$urandom, stc_pkg::PAYLOAD_W'($urandom)};
      repeat (cycles - 1) @(negedge clk);
    end
  endtask

  task automatic random_request(logic [stc_pkg::KEY_W-1:0] key);
    issue_request(key, stc_pkg::PAYLOAD_W'($urandom));
    hold_off(pick_gap());
  endtask

  task automatic wait_drained();
    hold_off(1);
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  function automatic logic [stc_pkg::KEY_W-1:0] stored_key();
    return tbl_key[$urandom_range(0, tbl_count - 1)];
  endfunction

  task automatic test_empty_and_ordering();
    issue_request(32'h8000_0000, 16'h1234);
    issue_request(32'hFFFF_FFFF, 16'hFFFF);
    issue_request(32'h0000_0000, 16'h0000);
    issue_request(32'h7FFF_FFFF, 16'hAAAA);
    hold_off(3);
    issue_request(32'h8000_0001, 16'h5555);
    issue_request(32'hFFFF_FFFE, 16'h0001);
    issue_request(32'h0000_0001, 16'h8000);
  endtask

  task automatic test_replace();
    issue_request(32'h8000_0000, 16'h5555);
    issue_request(32'h0000_0000, 16'hFFFF);
    hold_off(2);
    issue_request(32'hFFFF_FFFF, 16'h0000);
    issue_request(32'h7FFF_FFFF, 16'h7FFF);
    issue_request(32'h7FFF_FFFF, 16'h0F0F);
  endtask

  task automatic test_fill_to_full();
    while (tbl_count < TABLE_DEPTH) begin
      if ($urandom_range(0, 4) == 0) random_request(stored_key());
      else random_request($urandom);
    end
  endtask

  task automatic test_full_table();
    issue_request(32'h4000_0000, 16'hBEEF);
    issue_request(32'h0000_0000, 16'h1111);
    issue_request(32'hFFFF_FFFF, 16'h2222);
    issue_request(32'hFFFF_FFFD, 16'h3333);
    issue_request(tbl_key[TABLE_DEPTH-1], 16'h4444);
    issue_request(tbl_key[TABLE_DEPTH/2], 16'h6666);
  endtask

  task automatic test_random_full();
    int n;
    for (n = 0; n < FULL_ITEMS; n++) begin
      if ($urandom_range(0, 9) < 7) random_request(stored_key());
      else random_request($urandom);
    end
  endtask

  always @(posedge clk) begin
    stc_pkg::rsp_t exp_rsp;
    if (rst_n && out_valid) begin
      if (pending_rsp.size() == 0) begin
        $error("unexpected response: outcome %0d slot %0d entry_count %0d",
               out_rsp.outcome, out_rsp.slot, out_rsp.entry_count);
        mismatches++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_rsp.outcome !== exp_rsp.outcome) begin
          $error("outcome: expected %0d, actual %0d", exp_rsp.outcome, out_rsp.outcome);
          mismatches++;
        end
        if (out_rsp.slot !== exp_rsp.slot) begin
          $error("slot: expected %0d, actual %0d", exp_rsp.slot, out_rsp.slot);
          mismatches++;
        end
        if (out_rsp.entry_count !== exp_rsp.entry_count) begin
          $error("entry_count: expected %0d, actual %0d",
                 exp_rsp.entry_count, out_rsp.entry_count);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || out_valid || (start && !busy)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n       = 1'b0;
    start       = 1'b0;
    in_req      = '0;
    tbl_count   = 0;
    mismatches  = 0;
    idle_cycles = 0;
    burst_left  = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    test_empty_and_ordering();
    test_replace();
    wait_drained();
    test_fill_to_full();
    test_full_table();
    test_random_full();

    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_rsp.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
